@@ sv/lfmc_pkg.sv @@
package lfmc_pkg;

	localparam int unsigned TICK_COUNT_WIDTH = 16;
	localparam int unsigned LEVEL_W = 10;
	localparam int unsigned DIST_W = 16;
	localparam int unsigned SPEED_W = 8;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [SPEED_W-1:0] TURN_FAST = 8'd20;
	localparam logic [SPEED_W-1:0] TURN_SLOW = 8'd5;

	localparam logic [LEVEL_W-1:0] WHITE_FLOOR_RST = 10'd600;
	localparam logic [LEVEL_W-1:0] BLACK_CEIL_RST = 10'd400;
	localparam logic [DIST_W-1:0] STOP_DIST_RST = 16'd200;
	localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST = 8'd20;
	localparam logic [LIMIT_W-1:0] TIME_LIMIT_RST = 16'd65535;

	typedef enum logic [2:0] {
		MODE_INIT = 3'd0,
		MODE_STRAIGHT = 3'd1,
		MODE_LEFT = 3'd2,
		MODE_RIGHT = 3'd3,
		MODE_STOP = 3'd4,
		MODE_END = 3'd5
	} mode_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_WHITE_FLOOR = 3'd0,
		REG_BLACK_CEIL = 3'd1,
		REG_STOP_DIST = 3'd2,
		REG_CRUISE_SPEED = 3'd3,
		REG_TIME_LIMIT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] left_level;
		logic [LEVEL_W-1:0] right_level;
		logic start_pin;
		logic [DIST_W-1:0] nearest_distance;
	} tick_t;

	typedef struct packed {
		logic drive_valid;
		logic [SPEED_W-1:0] left_drive;
		logic [SPEED_W-1:0] right_drive;
		logic blink_request;
		logic [2:0] next_mode;
	} result_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] white_floor;
		logic [LEVEL_W-1:0] black_ceil;
		logic [DIST_W-1:0] stop_dist;
		logic [SPEED_W-1:0] cruise_speed;
		logic [LIMIT_W-1:0] time_limit;
	} cfg_t;

endpackage

@@ sv/lfmc_if.sv @@
interface lfmc_tick_if;
	logic valid;
	logic ready;
	lfmc_pkg::tick_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lfmc_result_if;
	logic valid;
	logic ready;
	lfmc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lfmc_cfg_if;
	logic valid;
	logic ready;
	logic [lfmc_pkg::CFG_ADDR_W-1:0] addr;
	logic [lfmc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

@@ sv/line_follower_mode_control_top.sv @@
// each accepted tick's result is registered in the output buffer (main or skid)
// throughput: one tick per cycle unless the buffer is full; mode and tick counter
// update at the accepting edge; a two-entry output buffer keeps ticks flowing while
// one result waits; reset: arst_n clears mode to init, the tick counter to zero,
// the output buffer, and loads the configuration registers with their default values
module line_follower_mode_control_top #(
	parameter int unsigned TICK_COUNT_WIDTH = lfmc_pkg::TICK_COUNT_WIDTH
) (
	input logic clk,
	input logic arst_n,
	lfmc_tick_if.sink tick,
	lfmc_result_if.source result,
	lfmc_cfg_if.sink cfg
);

	lfmc_pkg::cfg_t regs;
	lfmc_pkg::result_t core_res;
	logic buf_ready;
	logic fire;

	assign tick.ready = buf_ready;
	assign fire = tick.valid && buf_ready;

	lfmc_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.regs(regs)
	);

	lfmc_core #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.tick(tick.data),
		.regs(regs),
		.res(core_res)
	);

	lfmc_skid u_skid (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(tick.valid),
		.in_ready(buf_ready),
		.in_data(core_res),
		.result(result)
	);

endmodule

@@ sv/lfmc_cfg_regs.sv @@
module lfmc_cfg_regs (
	input logic clk,
	input logic arst_n,
	lfmc_cfg_if.sink cfg,
	output lfmc_pkg::cfg_t regs
);

	lfmc_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.white_floor <= lfmc_pkg::WHITE_FLOOR_RST;
			regs_q.black_ceil <= lfmc_pkg::BLACK_CEIL_RST;
			regs_q.stop_dist <= lfmc_pkg::STOP_DIST_RST;
			regs_q.cruise_speed <= lfmc_pkg::CRUISE_SPEED_RST;
			regs_q.time_limit <= lfmc_pkg::TIME_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.addr)
				lfmc_pkg::REG_WHITE_FLOOR: begin
					regs_q.white_floor <= cfg.data[lfmc_pkg::LEVEL_W-1:0];
				end
				lfmc_pkg::REG_BLACK_CEIL: begin
					regs_q.black_ceil <= cfg.data[lfmc_pkg::LEVEL_W-1:0];
				end
				lfmc_pkg::REG_STOP_DIST: begin
					regs_q.stop_dist <= cfg.data[lfmc_pkg::DIST_W-1:0];
				end
				lfmc_pkg::REG_CRUISE_SPEED: begin
					regs_q.cruise_speed <= cfg.data[lfmc_pkg::SPEED_W-1:0];
				end
				lfmc_pkg::REG_TIME_LIMIT: begin
					regs_q.time_limit <= cfg.data[lfmc_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ sv/lfmc_core.sv @@
module lfmc_core #(
	parameter int unsigned TICK_COUNT_WIDTH = lfmc_pkg::TICK_COUNT_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input lfmc_pkg::tick_t tick,
	input lfmc_pkg::cfg_t regs,
	output lfmc_pkg::result_t res
);

	localparam int unsigned CMP_W =
		(TICK_COUNT_WIDTH > lfmc_pkg::LIMIT_W) ? TICK_COUNT_WIDTH : lfmc_pkg::LIMIT_W;

	lfmc_pkg::mode_t mode_q;
	lfmc_pkg::mode_t cur_mode;
	lfmc_pkg::mode_t nxt_mode;
	logic [TICK_COUNT_WIDTH-1:0] count_q;
	logic [TICK_COUNT_WIDTH-1:0] count_adv;
	logic [TICK_COUNT_WIDTH-1:0] count_nxt;
	logic near, l_white, r_white, l_black, r_black;

	always_comb begin
		count_adv = (count_q == '1) ? count_q : count_q + 1'b1;
		cur_mode = mode_q;
		if (CMP_W'(count_adv) >= CMP_W'(regs.time_limit)) begin
			cur_mode = lfmc_pkg::MODE_END;
		end

		near = tick.nearest_distance <= regs.stop_dist;
		l_white = tick.left_level > regs.white_floor;
		r_white = tick.right_level > regs.white_floor;
		l_black = tick.left_level < regs.black_ceil;
		r_black = tick.right_level < regs.black_ceil;

		count_nxt = count_adv;
		res.drive_valid = 1'b1;
		res.left_drive = '0;
		res.right_drive = '0;
		res.blink_request = 1'b0;
		nxt_mode = lfmc_pkg::MODE_END;

		case (cur_mode)
			lfmc_pkg::MODE_INIT: begin
				res.drive_valid = 1'b0;
				if (!tick.start_pin) begin
					count_nxt = '0;
					nxt_mode = lfmc_pkg::MODE_STRAIGHT;
				end else begin
					nxt_mode = lfmc_pkg::MODE_INIT;
				end
			end
			lfmc_pkg::MODE_STRAIGHT: begin
				res.left_drive = regs.cruise_speed;
				res.right_drive = regs.cruise_speed;
				if (near) begin
					nxt_mode = lfmc_pkg::MODE_STOP;
				end else if (l_white && r_black) begin
					nxt_mode = lfmc_pkg::MODE_RIGHT;
				end else if (r_white && l_black) begin
					nxt_mode = lfmc_pkg::MODE_LEFT;
				end else if (r_white && l_white) begin
					nxt_mode = lfmc_pkg::MODE_END;
				end else begin
					nxt_mode = lfmc_pkg::MODE_STRAIGHT;
				end
			end
			lfmc_pkg::MODE_LEFT, lfmc_pkg::MODE_RIGHT: begin
				res.left_drive = (cur_mode == lfmc_pkg::MODE_LEFT) ?
					lfmc_pkg::TURN_FAST : lfmc_pkg::TURN_SLOW;
				res.right_drive = (cur_mode == lfmc_pkg::MODE_LEFT) ?
					lfmc_pkg::TURN_SLOW : lfmc_pkg::TURN_FAST;
				if (near) begin
					nxt_mode = lfmc_pkg::MODE_STOP;
				end else if (r_black && l_black) begin
					nxt_mode = lfmc_pkg::MODE_STRAIGHT;
				end else if (r_white && l_white) begin
					nxt_mode = lfmc_pkg::MODE_END;
				end else begin
					nxt_mode = cur_mode;
				end
			end
			lfmc_pkg::MODE_STOP: begin
				nxt_mode = near ? lfmc_pkg::MODE_STOP : lfmc_pkg::MODE_STRAIGHT;
			end
			default: begin
				res.blink_request = 1'b1;
				nxt_mode = lfmc_pkg::MODE_END;
			end
		endcase

		res.next_mode = nxt_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lfmc_pkg::MODE_INIT;
			count_q <= '0;
		end else if (fire) begin
			mode_q <= nxt_mode;
			count_q <= count_nxt;
		end
	end

endmodule

@@ sv/lfmc_skid.sv @@
module lfmc_skid (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lfmc_pkg::result_t in_data,
	lfmc_result_if.source result
);

	logic main_valid_q, skid_valid_q;
	lfmc_pkg::result_t main_q, skid_q;
	logic push, pop, load_main;

	assign in_ready = !skid_valid_q;
	assign push = in_valid && in_ready;
	assign pop = main_valid_q && result.ready;
	assign load_main = !main_valid_q || pop;
	assign result.valid = main_valid_q;
	assign result.data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_main) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_main) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (push) begin
			skid_q <= in_data;
		end
	end

endmodule

@@ verif/line_follower_mode_control_top_test.sv @@
module line_follower_mode_control_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lfmc_pkg::*;

	localparam int LEVEL_TOP = (1 << LEVEL_W) - 1;
	localparam int DIST_TOP = (1 << DIST_W) - 1;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int PHASES = 6;
	localparam int PHASE_TICKS = 100;
	localparam int END_TICKS = 20;
	localparam int HOLD_OFF_CYCLES = 60;

	typedef enum {FINISH_LINE, FINISH_ZERO_LIMIT, FINISH_LIMIT_HIT} finish_t;

	typedef struct {
		tick_t stim;
		bit known;
		result_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lfmc_tick_if tick_bus();
	lfmc_result_if result_bus();
	lfmc_cfg_if cfg_bus();

	line_follower_mode_control_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_bus),
		.result(result_bus),
		.cfg(cfg_bus)
	);

	// shadow of the block
	cfg_t regs_now = '{WHITE_FLOOR_RST, BLACK_CEIL_RST, STOP_DIST_RST, CRUISE_SPEED_RST,
		TIME_LIMIT_RST};
	mode_t mode_now = MODE_INIT;
	logic [TICK_COUNT_WIDTH-1:0] ticks_now = '0;

	result_t owed_results[$];
	int mismatches = 0;
	bit row_known = 1'b0;
	result_t row_want = '0;
	bit steady = 1'b0;
	bit hold_off_req = 1'b0;

	plan_row_t plan [20] = '{
		'{'{10'd0, 10'd0, 1'b1, 16'hFFFF}, 1'b1, '{1'b0, 8'd0, 8'd0, 1'b0, MODE_INIT}},
		'{'{10'd1023, 10'd1023, 1'b1, 16'd0}, 1'b1, '{1'b0, 8'd0, 8'd0, 1'b0, MODE_INIT}},
		'{'{10'd0, 10'd1023, 1'b0, 16'd0}, 1'b1, '{1'b0, 8'd0, 8'd0, 1'b0, MODE_STRAIGHT}},
		'{'{10'd1023, 10'd0, 1'b1, 16'hFFFF}, 1'b1,
			'{1'b1, CRUISE_SPEED_RST, CRUISE_SPEED_RST, 1'b0, MODE_RIGHT}},
		'{'{10'd0, 10'd0, 1'b0, 16'd4096}, 1'b1,
			'{1'b1, TURN_SLOW, TURN_FAST, 1'b0, MODE_STRAIGHT}},
		'{'{10'd0, 10'd1023, 1'b1, 16'd1000}, 1'b1,
			'{1'b1, CRUISE_SPEED_RST, CRUISE_SPEED_RST, 1'b0, MODE_LEFT}},
		'{'{10'd0, 10'd1023, 1'b0, 16'd201}, 1'b1,
			'{1'b1, TURN_FAST, TURN_SLOW, 1'b0, MODE_LEFT}},
		'{'{10'd0, 10'd1023, 1'b1, 16'd200}, 1'b1,
			'{1'b1, TURN_FAST, TURN_SLOW, 1'b0, MODE_STOP}},
		'{'{10'd1023, 10'd1023, 1'b0, 16'd200}, 1'b1, '{1'b1, 8'd0, 8'd0, 1'b0, MODE_STOP}},
		'{'{10'd1023, 10'd1023, 1'b1, 16'd201}, 1'b1,
			'{1'b1, 8'd0, 8'd0, 1'b0, MODE_STRAIGHT}},
		'{'{10'd500, 10'd500, 1'b0, 16'hFFFF}, 1'b1,
			'{1'b1, CRUISE_SPEED_RST, CRUISE_SPEED_RST, 1'b0, MODE_STRAIGHT}},
		'{'{10'd1023, 10'd1023, 1'b1, 16'd0}, 1'b1,
			'{1'b1, CRUISE_SPEED_RST, CRUISE_SPEED_RST, 1'b0, MODE_STOP}},
		'{'{10'd0, 10'd0, 1'b0, 16'hFFFF}, 1'b1, '{1'b1, 8'd0, 8'd0, 1'b0, MODE_STRAIGHT}},
		// threshold edges, checked by the predictor
		'{'{10'd600, 10'd399, 1'b1, 16'd1000}, 1'b0, '0},
		'{'{10'd601, 10'd399, 1'b0, 16'd1000}, 1'b0, '0},
		'{'{10'd400, 10'd0, 1'b1, 16'd1000}, 1'b0, '0},
		'{'{10'd399, 10'd399, 1'b0, 16'd1000}, 1'b0, '0},
		'{'{10'd0, 10'd601, 1'b1, 16'd201}, 1'b0, '0},
		'{'{10'd1023, 10'd0, 1'b0, 16'd5000}, 1'b0, '0},
		'{'{10'd0, 10'd0, 1'b1, 16'd5000}, 1'b0, '0}
	};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic result_t advance_mode(tick_t t);
		result_t r;
		mode_t cur;
		mode_t nxt;
		logic near, l_white, r_white, l_black, r_black;
		r = '0;
		r.drive_valid = 1'b1;
		if (ticks_now != '1)
			ticks_now = ticks_now + 1'b1;
		cur = mode_now;
		if (ticks_now >= regs_now.time_limit)
			cur = MODE_END;
		near = t.nearest_distance <= regs_now.stop_dist;
		l_white = t.left_level > regs_now.white_floor;
		r_white = t.right_level > regs_now.white_floor;
		l_black = t.left_level < regs_now.black_ceil;
		r_black = t.right_level < regs_now.black_ceil;
		case (cur)
			MODE_INIT: begin
				r.drive_valid = 1'b0;
				if (!t.start_pin) begin
					ticks_now = '0;
					nxt = MODE_STRAIGHT;
				end else begin
					nxt = MODE_INIT;
				end
			end
			MODE_STRAIGHT: begin
				r.left_drive = regs_now.cruise_speed;
				r.right_drive = regs_now.cruise_speed;
				if (near) nxt = MODE_STOP;
				else if (l_white && r_black) nxt = MODE_RIGHT;
				else if (r_white && l_black) nxt = MODE_LEFT;
				else if (l_white && r_white) nxt = MODE_END;
				else nxt = MODE_STRAIGHT;
			end
			MODE_LEFT, MODE_RIGHT: begin
				r.left_drive = (cur == MODE_LEFT) ? TURN_FAST : TURN_SLOW;
				r.right_drive = (cur == MODE_LEFT) ? TURN_SLOW : TURN_FAST;
				if (near) nxt = MODE_STOP;
				else if (l_black && r_black) nxt = MODE_STRAIGHT;
				else if (l_white && r_white) nxt = MODE_END;
				else nxt = cur;
			end
			MODE_STOP: nxt = near ? MODE_STOP : MODE_STRAIGHT;
			default: begin
				r.blink_request = 1'b1;
				nxt = MODE_END;
			end
		endcase
		mode_now = nxt;
		r.next_mode = nxt;
		return r;
	endfunction

	function automatic void apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_WHITE_FLOOR: regs_now.white_floor = val[LEVEL_W-1:0];
			REG_BLACK_CEIL: regs_now.black_ceil = val[LEVEL_W-1:0];
			REG_STOP_DIST: regs_now.stop_dist = val[DIST_W-1:0];
			REG_CRUISE_SPEED: regs_now.cruise_speed = val[SPEED_W-1:0];
			REG_TIME_LIMIT: regs_now.time_limit = val[LIMIT_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
		if (seen !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
			mismatches++;
		end
	endfunction

	function automatic int idle_cycles();
		if ($urandom_range(0, 3) != 0)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 30);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 2))
			0: if (regs_now.white_floor < LEVEL_TOP)
				return LEVEL_W'($urandom_range(regs_now.white_floor + 1, LEVEL_TOP));
			1: if (regs_now.black_ceil > 0)
				return LEVEL_W'($urandom_range(0, regs_now.black_ceil - 1));
			default: ;
		endcase
		return LEVEL_W'($urandom_range(0, LEVEL_TOP));
	endfunction

	// unless wild, never both sensors on white, so the run stays out of end mode
	function automatic tick_t random_tick(bit wild);
		tick_t t;
		t.left_level = pick_level();
		t.right_level = pick_level();
		if (!wild && t.left_level > regs_now.white_floor &&
			t.right_level > regs_now.white_floor)
			t.right_level = LEVEL_W'($urandom_range(0, regs_now.white_floor));
		t.start_pin = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0)
			t.nearest_distance = DIST_W'($urandom_range(0, regs_now.stop_dist));
		else
			t.nearest_distance = DIST_W'($urandom_range(0, DIST_TOP));
		return t;
	endfunction

	always @(posedge clk) begin : watch
		result_t got;
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready) begin
				if (owed_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, got %h", $time,
						result_bus.data);
					mismatches++;
				end else begin
					got = owed_results.pop_front();
					check_field("drive_valid", 8'(got.drive_valid),
						8'(result_bus.data.drive_valid));
					check_field("left_drive", got.left_drive, result_bus.data.left_drive);
					check_field("right_drive", got.right_drive, result_bus.data.right_drive);
					check_field("blink_request", 8'(got.blink_request),
						8'(result_bus.data.blink_request));
					check_field("next_mode", 8'(got.next_mode),
						8'(result_bus.data.next_mode));
				end
			end
			if (cfg_bus.valid && cfg_bus.ready)
				apply_reg(cfg_bus.addr, cfg_bus.data);
			if (tick_bus.valid && tick_bus.ready) begin
				got = advance_mode(tick_bus.data);
				owed_results.push_back(row_known ? row_want : got);
			end
		end
	end

	initial begin : sink_side
		int gap;
		result_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_bus.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				result_bus.ready <= 1'b1;
			end else begin
				gap = steady ? 0 : idle_cycles();
				if (gap > 0) begin
					result_bus.ready <= 1'b0;
					repeat (gap) @(negedge clk);
					result_bus.ready <= 1'b1;
				end else begin
					result_bus.ready <= 1'b1;
				end
			end
		end
	end

	task automatic send_tick(tick_t t, bit known, result_t want);
		int gap;
		row_known = known;
		row_want = want;
		tick_bus.data <= t;
		tick_bus.valid <= 1'b1;
		do @(posedge clk); while (!tick_bus.ready);
		@(negedge clk);
		gap = steady ? 0 : idle_cycles();
		if (gap > 0) begin
			tick_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		tick_bus.valid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_bus.addr <= idx;
		cfg_bus.data <= val;
		cfg_bus.valid <= 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure_phase(int p);
		logic [CFG_DATA_W-1:0] w, b, d, c, lim;
		case (p)
			0: begin
				w = CFG_DATA_W'(LEVEL_TOP);
				b = '0;
				d = CFG_DATA_W'(DIST_TOP);
				c = '0;
				lim = TIME_LIMIT_RST;
			end
			1: begin
				w = '0;
				b = CFG_DATA_W'(LEVEL_TOP);
				d = '0;
				c = 16'd255;
				lim = CFG_DATA_W'($urandom_range(5000, 65535));
			end
			default: begin
				w = CFG_DATA_W'($urandom_range(300, LEVEL_TOP));
				b = CFG_DATA_W'($urandom_range(0, w));
				d = CFG_DATA_W'($urandom_range(0, 3000));
				c = CFG_DATA_W'($urandom_range(0, 255));
				lim = CFG_DATA_W'($urandom_range(5000, 65535));
			end
		endcase
		write_reg(REG_WHITE_FLOOR, w);
		write_reg(REG_BLACK_CEIL, b);
		write_reg(REG_STOP_DIST, d);
		write_reg(REG_CRUISE_SPEED, c);
		write_reg(REG_TIME_LIMIT, lim);
		// writes to unmapped indexes must leave the registers alone
		if (p == 2)
			for (int s = REG_SPARE_LO; s <= REG_SPARE_HI; s++)
				write_reg(CFG_ADDR_W'(s), CFG_DATA_W'($urandom_range(0, DIST_TOP)));
	endtask

	initial begin : stimulus
		finish_t ending;
		tick_bus.valid = 1'b0;
		tick_bus.data = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.addr = '0;
		cfg_bus.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_tick(plan[i].stim, plan[i].known, plan[i].want);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			configure_phase(p);
			steady = (p == 4);
			for (int i = 0; i < PHASE_TICKS; i++) begin
				if (p == 2 && i == 30)
					hold_off_req = 1'b1;
				if (p == 3 && i == 50)
					drain();
				send_tick(random_tick(1'b0), 1'b0, '0);
			end
		end
		steady = 1'b0;
		drain();

		// end mode is terminal, so only one way into it per run
		ending = finish_t'($urandom_range(0, 2));
		case (ending)
			FINISH_LINE: begin
				write_reg(REG_WHITE_FLOOR, CFG_DATA_W'(WHITE_FLOOR_RST));
				write_reg(REG_STOP_DIST, STOP_DIST_RST);
				while (mode_now == MODE_STOP)
					send_tick('{10'd0, 10'd0, 1'b1, 16'hFFFF}, 1'b0, '0);
				send_tick('{10'd1023, 10'd1023, 1'b0, 16'hFFFF}, 1'b0, '0);
			end
			FINISH_ZERO_LIMIT: write_reg(REG_TIME_LIMIT, '0);
			default: begin
				write_reg(REG_TIME_LIMIT, CFG_DATA_W'(ticks_now + $urandom_range(3, 20)));
				while (mode_now != MODE_END)
					send_tick(random_tick(1'b0), 1'b0, '0);
			end
		endcase
		for (int i = 0; i < END_TICKS; i++)
			send_tick(random_tick(1'b1), 1'b0, '0);
		drain();
		repeat (4) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ line_follower_mode_control_top.f @@
sv/lfmc_pkg.sv
sv/lfmc_if.sv
sv/lfmc_cfg_regs.sv
sv/lfmc_core.sv
sv/lfmc_skid.sv
sv/line_follower_mode_control_top.sv
verif/line_follower_mode_control_top_test.sv
